// ===== hdl/bresenham_line_rasterizer_top_assert.svh =====
// Assertion helpers shared by the rasterizer RTL.
// Both expect clk and rst_n in scope.
`ifndef BRESENHAM_LINE_RASTERIZER_TOP_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BLR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BLR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/blr_pkg.sv =====
`default_nettype none

package blr_pkg;

    localparam int INDEX_BITS  = 19;
    localparam int COLOUR_BITS = 8;
    localparam int CHAN_BITS   = 10;
    localparam logic [COLOUR_BITS-1:0] COLOUR_MAX = 8'd255;

    typedef enum logic
    {
        FUNC_LOAD = 1'b0,
        FUNC_STEP = 1'b1
    } func_t;

    typedef struct packed
    {
        logic                   write_enable;
        logic [INDEX_BITS-1:0]  pixel_index;
        logic [COLOUR_BITS-1:0] red;
        logic [COLOUR_BITS-1:0] green;
        logic [COLOUR_BITS-1:0] blue;
        logic                   last_pixel;
    } pixel_t;

    // Clamp a 10-bit channel request to the 8-bit range.
    function automatic logic [COLOUR_BITS-1:0] sat_colour(input logic [CHAN_BITS-1:0] v);
        logic [COLOUR_BITS-1:0] r;
        r = (v > CHAN_BITS'(COLOUR_MAX)) ? COLOUR_MAX : v[COLOUR_BITS-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bresenham_line_rasterizer_top.sv =====
// Bresenham line rasterizer with frame clipping and pixel addressing.
//
// Input channel (in_valid / in_stall): a load beat (func = load) takes two
// signed endpoints and a colour and produces nothing; a step beat (func =
// step) produces one pixel of the current line. A step with no line loaded
// is swallowed. A load in the middle of a line replaces it.
// Output channel (out_valid / out_stall): one beat per pixel carrying
// write_enable, pixel_index, the saturated colour and last_pixel.
//
// Throughput: one input beat per clock, one pixel per clock, while in_stall
// and out_stall are low. The error update, clip test and index multiply all
// sit between the line-state registers and the output register. A step's
// pixel is registered in main, or parked in skid when main is held.
//
// Stall: a two-entry output stage (main register plus skid register) sits
// between the sides. in_stall is the registered skid-full flag, so it
// rises only once a pixel is parked in the skid entry, and the input keeps
// flowing while a single pixel waits to be taken.
// Reset: asynchronous, active low; clears the output and skid valids and
// the line-active flag, so no line is loaded afterwards.
`default_nettype none

`include "bresenham_line_rasterizer_top_assert.svh"

module bresenham_line_rasterizer_top
    import blr_pkg::*;
#(
    parameter int FRAME_WIDTH  = 1024,
    parameter int FRAME_HEIGHT = 512,
    parameter int COORD_BITS   = 12
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         func,
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    input  logic [CHAN_BITS-1:0]         red_in,
    input  logic [CHAN_BITS-1:0]         green_in,
    input  logic [CHAN_BITS-1:0]         blue_in,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         write_enable,
    output logic [INDEX_BITS-1:0]        pixel_index,
    output logic [COLOUR_BITS-1:0]       red_out,
    output logic [COLOUR_BITS-1:0]       green_out,
    output logic [COLOUR_BITS-1:0]       blue_out,
    output logic                         last_pixel
);

    localparam int CB        = COORD_BITS;
    localparam int ERR_BITS  = CB + 3;
    // Wide enough for a signed coordinate and for the frame limits.
    localparam int CMP_BITS  = ((CB > 12) ? CB : 12) + 1;
    localparam int ROW_BITS  = $clog2(FRAME_HEIGHT);
    localparam int COL_BITS  = $clog2(FRAME_WIDTH);
    localparam int PROD_BITS = ROW_BITS + COL_BITS;
    localparam int CALC_BITS = (PROD_BITS > INDEX_BITS) ? PROD_BITS : INDEX_BITS;

    // Line state
    logic                line_active_reg;
    logic signed [CB-1:0] major_pos_reg,  major_pos_next;
    logic signed [CB-1:0] minor_pos_reg,  minor_pos_next;
    logic signed [CB-1:0] major_stop_reg;
    logic signed [ERR_BITS-1:0] error_acc_reg, error_acc_next;
    logic signed [CB:0]  major_span_reg;
    logic [CB:0]         minor_incr_reg;
    logic                minor_down_reg;
    logic                steep_line_reg;
    logic [COLOUR_BITS-1:0] red_reg, green_reg, blue_reg;

    // Output stage
    logic   out_valid_reg, out_valid_next;
    logic   skid_valid_reg, skid_valid_next;
    pixel_t main_reg;
    pixel_t skid_reg;
    pixel_t pix;
    logic   load_main, main_from_skid, load_skid;

    logic accept, do_load, do_step, take, at_last;

    assign accept  = in_valid && !in_stall;
    assign do_load = accept && (func_t'(func) == FUNC_LOAD);
    assign do_step = accept && (func_t'(func) == FUNC_STEP) && line_active_reg;
    assign take    = out_valid_reg && !out_stall;
    assign at_last = (major_pos_reg == major_stop_reg);

    // ---------------------------------------------------------------
    // Load: pick the major axis and order the endpoints along it.
    // ---------------------------------------------------------------
    logic signed [CB:0] dx, dy, span_load, dmin;
    logic [CB:0] mag_dx, mag_dy, mag_dmin;
    logic steep_load, swap_ends;
    logic signed [CB-1:0] a_maj, a_min, b_maj, b_min;
    logic signed [CB-1:0] first_maj, first_min, last_maj, last_min;

    always_comb
    begin
        dx     = {x_start[CB-1], x_start} - {x_end[CB-1], x_end};
        dy     = {y_start[CB-1], y_start} - {y_end[CB-1], y_end};
        mag_dx = dx[CB] ? (~dx + 1'b1) : dx;
        mag_dy = dy[CB] ? (~dy + 1'b1) : dy;
        steep_load = mag_dx < mag_dy;

        a_maj = steep_load ? y_start : x_start;
        a_min = steep_load ? x_start : y_start;
        b_maj = steep_load ? y_end   : x_end;
        b_min = steep_load ? x_end   : y_end;

        swap_ends = a_maj > b_maj;
        first_maj = swap_ends ? b_maj : a_maj;
        first_min = swap_ends ? b_min : a_min;
        last_maj  = swap_ends ? a_maj : b_maj;
        last_min  = swap_ends ? a_min : b_min;

        span_load = {last_maj[CB-1], last_maj} - {first_maj[CB-1], first_maj};
        dmin      = {last_min[CB-1], last_min} - {first_min[CB-1], first_min};
        mag_dmin  = dmin[CB] ? (~dmin + 1'b1) : dmin;
    end

    // ---------------------------------------------------------------
    // Step: advance along the major axis, carry into the minor axis.
    // ---------------------------------------------------------------
    logic signed [ERR_BITS-1:0] err_sum, span_ext;
    logic minor_move;

    always_comb
    begin
        span_ext   = ERR_BITS'(major_span_reg);
        err_sum    = error_acc_reg + $signed({2'b00, minor_incr_reg});
        minor_move = err_sum > span_ext;
        error_acc_next = minor_move ? (err_sum - (span_ext <<< 1)) : err_sum;
        minor_pos_next = minor_move ? (minor_down_reg ? minor_pos_reg - 1'b1
                                                      : minor_pos_reg + 1'b1)
                                    : minor_pos_reg;
        major_pos_next = major_pos_reg + 1'b1;
    end

    // ---------------------------------------------------------------
    // Pixel: clip to the frame and flip vertically into an index.
    // ---------------------------------------------------------------
    logic signed [CB-1:0] px, py;
    logic signed [CMP_BITS-1:0] px_ext, py_ext, row_ext;
    logic in_frame;
    logic [CALC_BITS-1:0] index_calc;

    always_comb
    begin
        px      = steep_line_reg ? minor_pos_reg : major_pos_reg;
        py      = steep_line_reg ? major_pos_reg : minor_pos_reg;
        px_ext  = {{(CMP_BITS-CB){px[CB-1]}}, px};
        py_ext  = {{(CMP_BITS-CB){py[CB-1]}}, py};
        in_frame = !px_ext[CMP_BITS-1]
                && (px_ext < $signed(CMP_BITS'(FRAME_WIDTH)))
                && (py_ext >= $signed(CMP_BITS'(1)))
                && (py_ext <= $signed(CMP_BITS'(FRAME_HEIGHT)));
        row_ext = $signed(CMP_BITS'(FRAME_HEIGHT)) - py_ext;
        index_calc = CALC_BITS'(row_ext[ROW_BITS-1:0]) * CALC_BITS'(FRAME_WIDTH)
                   + CALC_BITS'(px_ext[COL_BITS-1:0]);

        pix.write_enable = in_frame;
        pix.pixel_index  = in_frame ? index_calc[INDEX_BITS-1:0] : '0;
        pix.red          = red_reg;
        pix.green        = green_reg;
        pix.blue         = blue_reg;
        pix.last_pixel   = at_last;
    end

    // ---------------------------------------------------------------
    // Output stage steering: fill main when free, else park in skid.
    // ---------------------------------------------------------------
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_main       = 1'b0;
        main_from_skid  = 1'b0;
        load_skid       = 1'b0;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                main_from_skid  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || take)
        begin
            out_valid_next = do_step;
            load_main      = do_step;
        end
        else if (do_step)
        begin
            load_skid       = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (do_load)
                line_active_reg <= 1'b1;
            else if (do_step && at_last)
                line_active_reg <= 1'b0;
        end
    end

    // Line state and pixel payload
    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            major_pos_reg  <= first_maj;
            minor_pos_reg  <= first_min;
            major_stop_reg <= last_maj;
            major_span_reg <= span_load;
            minor_incr_reg <= {mag_dmin[CB-1:0], 1'b0};
            minor_down_reg <= dmin[CB];
            steep_line_reg <= steep_load;
            error_acc_reg  <= '0;
            red_reg        <= sat_colour(red_in);
            green_reg      <= sat_colour(green_in);
            blue_reg       <= sat_colour(blue_in);
        end
        else if (do_step && !at_last)
        begin
            major_pos_reg <= major_pos_next;
            minor_pos_reg <= minor_pos_next;
            error_acc_reg <= error_acc_next;
        end

        if (load_main)
            main_reg <= pix;
        else if (main_from_skid)
            main_reg <= skid_reg;
        if (load_skid)
            skid_reg <= pix;
    end

    assign in_stall     = skid_valid_reg;
    assign out_valid    = out_valid_reg;
    assign write_enable = main_reg.write_enable;
    assign pixel_index  = main_reg.pixel_index;
    assign red_out      = main_reg.red;
    assign green_out    = main_reg.green;
    assign blue_out     = main_reg.blue;
    assign last_pixel   = main_reg.last_pixel;

    // A parked pixel always has one ahead of it in the main register.
    `BLR_ASSERT_NOW(a_skid_behind_main, skid_valid_reg, out_valid_reg,
        "skid entry full while main register empty")
    // Clipped pixels carry a zero index.
    `BLR_ASSERT_NOW(a_clip_zero_index, out_valid_reg && !main_reg.write_enable,
        main_reg.pixel_index == '0, "clipped pixel with non-zero index")
    // A step into a free output stage shows its pixel next cycle.
    `BLR_ASSERT_NEXT(a_step_emits, do_step && !out_valid_reg, out_valid_reg,
        "step beat produced no pixel")
    // The last pixel ends the line.
    `BLR_ASSERT_NEXT(a_last_ends_line, do_step && at_last, !line_active_reg,
        "line still active after its last pixel")

endmodule

`default_nettype wire
